[hdl/assert_macros.svh]
// Assertion macros for the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AST_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[hdl/arp_pkg.sv]
// Types and constants of the ARP cache and responder.
package arp_pkg;

	// Field widths
	localparam int CMD_W    = 3;
	localparam int OPC_W    = 16;
	localparam int IP_W     = 32;
	localparam int MAC_W    = 48;
	localparam int STATUS_W = 4;

	// Stream data widths, padded to whole bytes
	localparam int IN_FIELDS_W  = CMD_W + OPC_W + IP_W + MAC_W + IP_W;
	localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = STATUS_W + MAC_W + IP_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	// Table size; entry indexes are carried at the width of the largest table
	localparam int DEF_ENTRIES = 16;
	localparam int ENTRIES_CAP = 256;
	localparam int IDX_W       = $clog2(ENTRIES_CAP);

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 48;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_IP  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC = 1'd1;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_PACKET  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ADD     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_RESOLVE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

	// ARP opcodes
	localparam logic [OPC_W-1:0] OP_REQUEST = 16'd1;
	localparam logic [OPC_W-1:0] OP_REPLY   = 16'd2;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_DONE            = 4'd0;
	localparam logic [STATUS_W-1:0] ST_FULL            = 4'd1;
	localparam logic [STATUS_W-1:0] ST_HIT             = 4'd2;
	localparam logic [STATUS_W-1:0] ST_MISS            = 4'd3;
	localparam logic [STATUS_W-1:0] ST_REPLY           = 4'd4;
	localparam logic [STATUS_W-1:0] ST_REPLY_UNLEARNED = 4'd5;
	localparam logic [STATUS_W-1:0] ST_NOT_OURS        = 4'd6;
	localparam logic [STATUS_W-1:0] ST_REPLY_SEEN      = 4'd7;
	localparam logic [STATUS_W-1:0] ST_BAD_OPCODE      = 4'd8;

	// Search token handed from cell to cell
	typedef struct packed {
		logic              vld;
		logic [IP_W-1:0]   key;
		logic              hit;
		logic [IDX_W-1:0]  hit_idx;
		logic [MAC_W-1:0]  hit_mac;
		logic              free;
		logic [IDX_W-1:0]  free_idx;
	} arp_tok_t;

	// Table update broadcast to all cells
	typedef struct packed {
		logic              wr;
		logic              inv;
		logic              clr;
		logic [IDX_W-1:0]  idx;
		logic [IP_W-1:0]   ip;
		logic [MAC_W-1:0]  mac;
	} arp_upd_t;

endpackage

[hdl/arp_cell.sv]
// One table entry of the ARP cache with its stage of the search chain.
module arp_cell #(
	parameter int CELL_IDX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  arp_pkg::arp_tok_t tok_in,
	input  arp_pkg::arp_upd_t upd,
	output arp_pkg::arp_tok_t tok_out
);

	logic                        valid_q;
	logic [arp_pkg::IP_W-1:0]    ip_q;
	logic [arp_pkg::MAC_W-1:0]   mac_q;
	logic                        tok_vld_q;
	arp_pkg::arp_tok_t           tok_q;
	arp_pkg::arp_tok_t           tok_nxt;
	logic                        sel;

	assign sel = (upd.idx == arp_pkg::IDX_W'(CELL_IDX));

	// Entry valid bit; clear wipes every cell at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (upd.clr) begin
			valid_q <= 1'b0;
		end else if (upd.wr && sel) begin
			valid_q <= 1'b1;
		end else if (upd.inv && sel) begin
			valid_q <= 1'b0;
		end
	end

	// Entry payload
	always_ff @(posedge clk) begin
		if (upd.wr && sel) begin
			ip_q  <= upd.ip;
			mac_q <= upd.mac;
		end
	end

	// Lowest match and lowest free slot win: later cells leave found flags alone
	always_comb begin
		tok_nxt = tok_in;
		if (!tok_in.hit && valid_q && (ip_q == tok_in.key)) begin
			tok_nxt.hit     = 1'b1;
			tok_nxt.hit_idx = arp_pkg::IDX_W'(CELL_IDX);
			tok_nxt.hit_mac = mac_q;
		end
		if (!tok_in.free && !valid_q) begin
			tok_nxt.free     = 1'b1;
			tok_nxt.free_idx = arp_pkg::IDX_W'(CELL_IDX);
		end
	end

	// Token register towards the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_vld_q <= 1'b0;
		end else begin
			tok_vld_q <= tok_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_nxt;
	end

	always_comb begin
		tok_out     = tok_q;
		tok_out.vld = tok_vld_q;
	end

endmodule

[hdl/arp_cache_and_responder.sv]
// Top level of the ARP cache and responder: control, cell chain and output register.
//
// Usage: one command per input transaction on s_tvalid/s_tready/s_tdata
// (packet, add/update, resolve, remove, clear); one result per command on
// m_tvalid/m_tready/m_tdata. The user writes own_ip and own_mac through
// cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
// Commands that search the table (add, resolve, remove, and a request for
// our own IP) are taken into the command and launch registers, pass the
// cell chain, where the search token steps through one cell per cycle, and
// then the capture register and the output register. Other commands go
// from the command register straight to the output register. One command
// is in work at a time: the next is accepted only once the result of the
// last has been taken into the output register.
// Reset clears every entry's valid bit and both configuration registers at
// once; no clearing pass is needed.
// A stalled receiver holds the result in the output register; the next
// command is still accepted and worked on, and only waits to finish until
// the output register is free.
module arp_cache_and_responder #(
	parameter int TABLE_ENTRIES = arp_pkg::DEF_ENTRIES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// cmd, opcode, sender IP, sender MAC, target IP (from bit 0 up), zero padded
	input  logic [arp_pkg::IN_DATA_W-1:0]     s_tdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// status, out_mac, out_ip (from bit 0 up), zero padded
	output logic [arp_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic                              cfg_we,
	input  logic [arp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [arp_pkg::CFG_DATA_W-1:0]    cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t                           state_q;
	logic [arp_pkg::IP_W-1:0]         own_ip_q;
	logic [arp_pkg::MAC_W-1:0]        own_mac_q;
	logic [arp_pkg::CMD_W-1:0]        cmd_q;
	logic [arp_pkg::OPC_W-1:0]        opcode_q;
	logic [arp_pkg::IP_W-1:0]         ip_q;
	logic [arp_pkg::MAC_W-1:0]        mac_q;
	logic [arp_pkg::IP_W-1:0]         tip_q;
	logic                             launch_q;
	arp_pkg::arp_tok_t                scan_q;
	logic                             m_tvalid_q;
	logic [arp_pkg::STATUS_W-1:0]     status_q;
	logic [arp_pkg::MAC_W-1:0]        omac_q;
	logic [arp_pkg::IP_W-1:0]         oip_q;

	logic [arp_pkg::CMD_W-1:0]        in_cmd;
	logic [arp_pkg::OPC_W-1:0]        in_opcode;
	logic [arp_pkg::IP_W-1:0]         in_ip;
	logic [arp_pkg::MAC_W-1:0]        in_mac;
	logic [arp_pkg::IP_W-1:0]         in_tip;
	logic                             accept;
	logic                             in_scan;
	logic                             req_ours;
	logic                             out_free;
	logic                             finish;
	logic [arp_pkg::STATUS_W-1:0]     status_d;
	logic [arp_pkg::MAC_W-1:0]        omac_d;
	logic [arp_pkg::IP_W-1:0]         oip_d;
	arp_pkg::arp_upd_t                upd;
	arp_pkg::arp_tok_t                tok [TABLE_ENTRIES+1];

	// Input field unpacking
	assign in_cmd    = s_tdata[2:0];
	assign in_opcode = s_tdata[18:3];
	assign in_ip     = s_tdata[50:19];
	assign in_mac    = s_tdata[98:51];
	assign in_tip    = s_tdata[130:99];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign in_scan  = (in_cmd == arp_pkg::CMD_ADD) || (in_cmd == arp_pkg::CMD_RESOLVE) ||
	                  (in_cmd == arp_pkg::CMD_REMOVE) ||
	                  ((in_cmd == arp_pkg::CMD_PACKET) && (in_opcode == arp_pkg::OP_REQUEST) &&
	                   (in_tip == own_ip_q));
	assign req_ours = (cmd_q == arp_pkg::CMD_PACKET) && (opcode_q == arp_pkg::OP_REQUEST) &&
	                  (tip_q == own_ip_q);
	assign out_free = !m_tvalid_q || m_tready;
	assign finish   = (state_q == ST_FIN) && out_free;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q  <= '0;
			own_mac_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				arp_pkg::REG_OWN_IP:  own_ip_q  <= cfg_data[arp_pkg::IP_W-1:0];
				arp_pkg::REG_OWN_MAC: own_mac_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Command register
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= in_cmd;
			opcode_q <= in_opcode;
			ip_q     <= in_ip;
			mac_q    <= in_mac;
			tip_q    <= in_tip;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			launch_q <= 1'b0;
		end else begin
			launch_q <= accept && in_scan;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= in_scan ? ST_SCAN : ST_FIN;
					end
				end
				ST_SCAN: begin
					if (tok[TABLE_ENTRIES].vld) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Search result at the end of the chain
	always_ff @(posedge clk) begin
		if ((state_q == ST_SCAN) && tok[TABLE_ENTRIES].vld) begin
			scan_q <= tok[TABLE_ENTRIES];
		end
	end

	// Token launched into the first cell
	always_comb begin
		tok[0]          = '0;
		tok[0].vld      = launch_q;
		tok[0].key      = ip_q;
	end

	// Cell chain
	for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
		arp_cell #(
			.CELL_IDX(g)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tok_in (tok[g]),
			.upd    (upd),
			.tok_out(tok[g+1])
		);
	end

	// Table update, applied as the result is produced
	always_comb begin
		upd     = '0;
		upd.ip  = ip_q;
		upd.mac = mac_q;
		if (finish) begin
			case (cmd_q)
				arp_pkg::CMD_ADD, arp_pkg::CMD_PACKET: begin
					if (cmd_q == arp_pkg::CMD_ADD || req_ours) begin
						upd.wr  = scan_q.hit || scan_q.free;
						upd.idx = scan_q.hit ? scan_q.hit_idx : scan_q.free_idx;
					end
				end
				arp_pkg::CMD_REMOVE: begin
					upd.inv = scan_q.hit;
					upd.idx = scan_q.hit_idx;
				end
				arp_pkg::CMD_CLEAR: upd.clr = 1'b1;
				default: ;
			endcase
		end
	end

	// Result decode
	always_comb begin
		status_d = arp_pkg::ST_DONE;
		omac_d   = '0;
		oip_d    = '0;
		case (cmd_q)
			arp_pkg::CMD_PACKET: begin
				if (opcode_q == arp_pkg::OP_REQUEST) begin
					if (!req_ours) begin
						status_d = arp_pkg::ST_NOT_OURS;
					end else begin
						status_d = (scan_q.hit || scan_q.free) ? arp_pkg::ST_REPLY
						                                        : arp_pkg::ST_REPLY_UNLEARNED;
						omac_d   = mac_q;
						oip_d    = ip_q;
					end
				end else if (opcode_q == arp_pkg::OP_REPLY) begin
					status_d = arp_pkg::ST_REPLY_SEEN;
				end else begin
					status_d = arp_pkg::ST_BAD_OPCODE;
				end
			end
			arp_pkg::CMD_ADD: begin
				status_d = (scan_q.hit || scan_q.free) ? arp_pkg::ST_DONE : arp_pkg::ST_FULL;
			end
			arp_pkg::CMD_RESOLVE: begin
				if (scan_q.hit) begin
					status_d = arp_pkg::ST_HIT;
					omac_d   = scan_q.hit_mac;
				end else begin
					status_d = arp_pkg::ST_MISS;
				end
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (finish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			status_q <= status_d;
			omac_q   <= omac_d;
			oip_q    <= oip_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(arp_pkg::OUT_DATA_W - arp_pkg::OUT_FIELDS_W){1'b0}},
	                   oip_q, omac_q, status_q};

	// own_mac is held in a register but drives no output of this block
	logic own_mac_unused;
	assign own_mac_unused = ^own_mac_q;

endmodule

[hdl/arp_chk.sv]
// Port checker for the ARP cache and responder, with its bind.
`include "assert_macros.svh"

module arp_chk (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic [arp_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  logic                              m_tvalid,
	input  logic                              m_tready
);

	logic [arp_pkg::STATUS_W-1:0] st;
	logic                         st_has_mac;
	logic                         st_has_ip;

	assign st = m_tdata[3:0];
	assign st_has_mac = (st == arp_pkg::ST_HIT) || (st == arp_pkg::ST_REPLY) ||
	                    (st == arp_pkg::ST_REPLY_UNLEARNED);
	assign st_has_ip  = (st == arp_pkg::ST_REPLY) || (st == arp_pkg::ST_REPLY_UNLEARNED);

	// A stalled result holds
	`AST_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// One command at a time: busy right after a transaction
	`AST_NXT(a_busy_after_in, s_tvalid && s_tready, !s_tready)
	// Status stays within the defined codes
	`AST_IMP(a_status_range, m_tvalid, st <= arp_pkg::ST_BAD_OPCODE)
	// Address fields are zero unless the status carries them
	`AST_IMP(a_fields_zero, m_tvalid && !st_has_mac, m_tdata[51:4] == '0 && m_tdata[83:52] == '0)
	`AST_IMP(a_ip_zero, m_tvalid && !st_has_ip, m_tdata[83:52] == '0)

endmodule

bind arp_cache_and_responder arp_chk u_arp_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tdata (m_tdata),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready)
);
